### rtl/rotated_framebuffer_bmp_readout_macros.svh
// Assertion macros shared by the readout checker.
`ifndef ROTATED_FRAMEBUFFER_BMP_READOUT_MACROS_SVH
`define ROTATED_FRAMEBUFFER_BMP_READOUT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define RFB_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define RFB_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after reset is seen.
`define RFB_CHECK_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

### rtl/rfb_pkg.sv
// Shared types, constants and color expansion tables of the framebuffer readout.
`default_nettype none

package rfb_pkg;

   localparam int MAX_DIMENSION_DEF = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int PIXEL_W     = 8;
   localparam int COLOR_W     = 8;
   localparam int OFFSET_W    = 22;
   localparam int INDEX_W     = 20;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 72;

   localparam int BMP_HEADER_BYTES = 54;

   localparam int RESET_SCREEN_WIDTH  = 320;
   localparam int RESET_SCREEN_HEIGHT = 240;
   localparam int RESET_NATIVE_WIDTH  = 320;
   localparam int RESET_NATIVE_HEIGHT = 240;

   // rsp_tdata field positions
   localparam int OFS_LSB   = 0;
   localparam int BLUE_LSB  = OFS_LSB + OFFSET_W;
   localparam int GREEN_LSB = BLUE_LSB + COLOR_W;
   localparam int RED_LSB   = GREEN_LSB + COLOR_W;
   localparam int FETCH_LSB = RED_LSB + COLOR_W;
   localparam int PAD_LSB   = FETCH_LSB + INDEX_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_NATIVE_WIDTH  = 3'd2,
      CSR_NATIVE_HEIGHT = 3'd3,
      CSR_ROTATION      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef logic [31:0][COLOR_W-1:0] exp5_type;
   typedef logic [63:0][COLOR_W-1:0] exp6_type;

   function automatic exp5_type build_exp5();
      exp5_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = COLOR_W'((i * 255) / 31);
      end
      return t;
   endfunction

   function automatic exp6_type build_exp6();
      exp6_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = COLOR_W'((i * 255) / 63);
      end
      return t;
   endfunction

   localparam exp5_type EXP5_TABLE = build_exp5();
   localparam exp6_type EXP6_TABLE = build_exp6();

endpackage

`default_nettype wire

### rtl/rotated_framebuffer_bmp_readout.sv
// Top level of the rotated framebuffer readout with BMP addressing.
//
// Usage:
//   req channel: one transfer per item. req_tuser is the command (0 begin
//   frame, 1 pixel word); req_tdata carries the RGB565 word fetched for the
//   current scan position. The block walks the screen in raster order and
//   wraps to the top-left after the last position.
//   rsp channel: one transfer per req transfer, in order. rsp_tuser flags a
//   real pixel, rsp_tlast marks the last pixel of the frame, rsp_tdata holds
//   the BMP byte offset, blue, green, red and the native index to fetch next.
//   csr port: dimension and rotation registers, written while idle.
// Pipeline: a req transfer is held in the input register, then in the result
//   register, which drives rsp_tvalid.
//   Throughput: one item per cycle while rsp_tready stays high, set by the single
//   registered pass through the offset and index multipliers.
// Stalls: a held-off result stays in the result register; one more item
//   waits in the input register, then req_tready drops.
// Reset: registers return to 320x240 screen and panel, no rotation; the
//   scan restarts at the top-left and both pipeline stages empty.
`default_nettype none

module rotated_framebuffer_bmp_readout import rfb_pkg::*; #(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // pixel_high, pixel_low
   input  wire logic                   req_tuser,   // command
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // bmp_offset, blue, green, red, fetch_index, zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tuser,   // pixel_valid
   output logic                        rsp_tlast,   // frame_last
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int POS_W = $clog2(MAX_DIMENSION);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIMENSION) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // registers hold the clamped sizes
   logic [DIM_W-1:0] screen_width_ff, screen_width_in;
   logic [DIM_W-1:0] screen_height_ff, screen_height_in;
   logic [DIM_W-1:0] native_width_ff, native_width_in;
   logic [DIM_W-1:0] native_height_ff, native_height_in;
   rot_type          rotation_ff, rotation_in;

   logic [POS_W-1:0] scan_col_ff, scan_col_in;
   logic [POS_W-1:0] scan_row_ff, scan_row_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cmd_ff;
   logic [PIXEL_W-1:0] s1_high_ff;
   logic [PIXEL_W-1:0] s1_low_ff;
   logic [POS_W-1:0]   s1_cur_col_ff;
   logic [POS_W-1:0]   s1_cur_row_ff;
   logic [POS_W-1:0]   s1_next_col_ff;
   logic [POS_W-1:0]   s1_next_row_ff;
   logic               s1_last_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   rsp_user_ff;
   logic                   rsp_last_ff;

   logic             advance;
   logic             req_accept;
   logic             on_screen;
   logic [POS_W-1:0] cur_col;
   logic [POS_W-1:0] cur_row;
   logic             col_wrap;
   logic             row_wrap;
   logic [POS_W-1:0] next_col;
   logic [POS_W-1:0] next_row;

   logic                pixel_valid;
   logic [OFFSET_W-1:0] bmp_offset;
   logic [COLOR_W-1:0]  blue;
   logic [COLOR_W-1:0]  green;
   logic [COLOR_W-1:0]  red;
   logic [INDEX_W-1:0]  fetch_index;
   logic                frame_last;

   // configuration
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      native_width_in  = native_width_ff;
      native_height_in = native_height_ff;
      rotation_in      = rotation_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = clamp_dim(csr_wdata);
            CSR_SCREEN_HEIGHT: screen_height_in = clamp_dim(csr_wdata);
            CSR_NATIVE_WIDTH:  native_width_in  = clamp_dim(csr_wdata);
            CSR_NATIVE_HEIGHT: native_height_in = clamp_dim(csr_wdata);
            CSR_ROTATION:      rotation_in      = rot_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // scan position
   assign on_screen = (DIM_W'(scan_col_ff) < screen_width_ff)
                    && (DIM_W'(scan_row_ff) < screen_height_ff);
   assign cur_col   = on_screen ? scan_col_ff : '0;
   assign cur_row   = on_screen ? scan_row_ff : '0;
   assign col_wrap  = (DIM_W'(cur_col) == screen_width_ff - DIM_W'(1));
   assign row_wrap  = (DIM_W'(cur_row) == screen_height_ff - DIM_W'(1));

   always_comb begin
      next_col = '0;
      next_row = '0;
      if (req_tuser == CMD_PIXEL) begin
         next_col = col_wrap ? '0 : POS_W'(cur_col + 1'b1);
         if (!col_wrap) begin
            next_row = cur_row;
         end else if (!row_wrap) begin
            next_row = POS_W'(cur_row + 1'b1);
         end
      end
   end

   assign scan_col_in = req_accept ? next_col : scan_col_ff;
   assign scan_row_in = req_accept ? next_row : scan_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= clamp_dim(CSR_DATA_W'(RESET_SCREEN_WIDTH));
         screen_height_ff <= clamp_dim(CSR_DATA_W'(RESET_SCREEN_HEIGHT));
         native_width_ff  <= clamp_dim(CSR_DATA_W'(RESET_NATIVE_WIDTH));
         native_height_ff <= clamp_dim(CSR_DATA_W'(RESET_NATIVE_HEIGHT));
         rotation_ff      <= ROT_0;
         scan_col_ff      <= '0;
         scan_row_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         native_width_ff  <= native_width_in;
         native_height_ff <= native_height_in;
         rotation_ff      <= rotation_in;
         scan_col_ff      <= scan_col_in;
         scan_row_ff      <= scan_row_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff      <= req_tuser;
         s1_high_ff     <= req_tdata[PIXEL_W-1:0];
         s1_low_ff      <= req_tdata[2*PIXEL_W-1:PIXEL_W];
         s1_cur_col_ff  <= cur_col;
         s1_cur_row_ff  <= cur_row;
         s1_next_col_ff <= next_col;
         s1_next_row_ff <= next_row;
         s1_last_ff     <= col_wrap && row_wrap;
      end
   end

   rfb_pixel_calc #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_calc (
      .command       (s1_cmd_ff),
      .pixel_high    (s1_high_ff),
      .pixel_low     (s1_low_ff),
      .cur_col       (s1_cur_col_ff),
      .cur_row       (s1_cur_row_ff),
      .next_col      (s1_next_col_ff),
      .next_row      (s1_next_row_ff),
      .last          (s1_last_ff),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .native_width  (native_width_ff),
      .native_height (native_height_ff),
      .rotation      (rotation_ff),
      .pixel_valid   (pixel_valid),
      .bmp_offset    (bmp_offset),
      .blue          (blue),
      .green         (green),
      .red           (red),
      .fetch_index   (fetch_index),
      .frame_last    (frame_last)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= {(RSP_TDATA_W - PAD_LSB)'(0), fetch_index, red, green, blue,
                         bmp_offset};
         rsp_user_ff <= pixel_valid;
         rsp_last_ff <= frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/rfb_pixel_calc.sv
// Result datapath: BMP offset, color expansion and rotated fetch index.
`default_nettype none

module rfb_pixel_calc import rfb_pkg::*; #(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
   localparam int DIM_W = $clog2(MAX_DIMENSION + 1),
   localparam int POS_W = $clog2(MAX_DIMENSION)
) (
   input  wire logic                command,
   input  wire logic [PIXEL_W-1:0]  pixel_high,
   input  wire logic [PIXEL_W-1:0]  pixel_low,
   input  wire logic [POS_W-1:0]    cur_col,
   input  wire logic [POS_W-1:0]    cur_row,
   input  wire logic [POS_W-1:0]    next_col,
   input  wire logic [POS_W-1:0]    next_row,
   input  wire logic                last,
   input  wire logic [DIM_W-1:0]    screen_width,
   input  wire logic [DIM_W-1:0]    screen_height,
   input  wire logic [DIM_W-1:0]    native_width,
   input  wire logic [DIM_W-1:0]    native_height,
   input  wire rot_type             rotation,
   output logic                     pixel_valid,
   output logic [OFFSET_W-1:0]      bmp_offset,
   output logic [COLOR_W-1:0]       blue,
   output logic [COLOR_W-1:0]       green,
   output logic [COLOR_W-1:0]       red,
   output logic [INDEX_W-1:0]       fetch_index,
   output logic                     frame_last
);

   localparam int STRIDE_W = DIM_W + 2;
   localparam int ROWB_W   = DIM_W + STRIDE_W;
   localparam int COLB_W   = POS_W + 2;

   logic [STRIDE_W-1:0] stride_sum;
   logic [STRIDE_W-1:0] stride;
   logic [DIM_W-1:0]    rows_below;
   logic [ROWB_W-1:0]   row_bytes;
   logic [COLB_W-1:0]   col_bytes;
   logic [4:0]          r5;
   logic [5:0]          g6;
   logic [4:0]          b5;
   logic [INDEX_W-1:0]  sx;
   logic [INDEX_W-1:0]  sy;
   logic [INDEX_W-1:0]  nw;
   logic [INDEX_W-1:0]  nh;
   logic [INDEX_W-1:0]  bx;
   logic [INDEX_W-1:0]  by;
   logic                is_pixel;

   assign is_pixel = (command == CMD_PIXEL);

   // row stride rounded up to 4 bytes
   assign stride_sum = STRIDE_W'({screen_width, 1'b0}) + STRIDE_W'(screen_width)
                     + STRIDE_W'(3);
   assign stride     = {stride_sum[STRIDE_W-1:2], 2'b00};

   // bottom-up rows
   assign rows_below = screen_height - DIM_W'(1) - DIM_W'(cur_row);
   assign row_bytes  = ROWB_W'(rows_below) * ROWB_W'(stride);
   assign col_bytes  = COLB_W'(cur_col) * COLB_W'(3);

   assign r5 = pixel_high[7:3];
   assign g6 = {pixel_high[2:0], pixel_low[7:5]};
   assign b5 = pixel_low[4:0];

   assign sx = INDEX_W'(next_col);
   assign sy = INDEX_W'(next_row);
   assign nw = INDEX_W'(native_width);
   assign nh = INDEX_W'(native_height);

   always_comb begin
      case (rotation)
         ROT_90: begin
            bx = nw - INDEX_W'(1) - sy;
            by = sx;
         end
         ROT_180: begin
            bx = nw - INDEX_W'(1) - sx;
            by = nh - INDEX_W'(1) - sy;
         end
         ROT_270: begin
            bx = sy;
            by = nh - INDEX_W'(1) - sx;
         end
         default: begin
            bx = sx;
            by = sy;
         end
      endcase
   end

   assign fetch_index = by * nw + bx;

   always_comb begin
      pixel_valid = is_pixel;
      frame_last  = is_pixel & last;
      if (is_pixel) begin
         bmp_offset = OFFSET_W'(BMP_HEADER_BYTES) + OFFSET_W'(row_bytes)
                    + OFFSET_W'(col_bytes);
         blue       = EXP5_TABLE[b5];
         green      = EXP6_TABLE[g6];
         red        = EXP5_TABLE[r5];
      end else begin
         bmp_offset = '0;
         blue       = '0;
         green      = '0;
         red        = '0;
      end
   end

endmodule

`default_nettype wire

### rtl/rfb_checker.sv
// Port-level checker for the framebuffer readout, bound to the top level.
`default_nettype none
`include "rotated_framebuffer_bmp_readout_macros.svh"

module rfb_checker import rfb_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser,
   input wire logic                   rsp_tlast
);

   `RFB_CHECK_RESET(a_reset_empties, !rsp_tvalid, "result valid after reset")

   `RFB_CHECK_NEXT(a_stall_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `RFB_CHECK_NOW(a_last_is_pixel, rsp_tvalid && rsp_tlast, rsp_tuser, "frame end on a non-pixel result")

   `RFB_CHECK_NOW(a_begin_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[FETCH_LSB-1:0] == '0, "begin result carries pixel data")

   `RFB_CHECK_NEXT(a_no_stall_drain, req_tvalid && req_tready && rsp_tready, rsp_tvalid || req_tready, "input taken but pipeline neither fills nor drains")

endmodule

bind rotated_framebuffer_bmp_readout rfb_checker u_rfb_checker (.*);

`default_nettype wire

### sim/rotated_framebuffer_bmp_readout_tb.sv
// Self-checking testbench for the rotated framebuffer readout with BMP addressing.
module rotated_framebuffer_bmp_readout_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rfb_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int LONG_HOLD     = 120;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int NUM_DIRECTED  = 25;

   typedef struct packed {
      logic                pixel_valid;
      logic [OFFSET_W-1:0] bmp_offset;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  red;
      logic [INDEX_W-1:0]  fetch_index;
      logic                frame_last;
   } readout_type;

   typedef struct packed {
      bit                    is_csr;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
      logic                  cmd;
      logic [PIXEL_W-1:0]    high;
      logic [PIXEL_W-1:0]    low;
      bit                    typed;
      readout_type           result;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the block's registers and scan position
   logic [CSR_DATA_W-1:0] shadow_screen_w = 11'(RESET_SCREEN_WIDTH);
   logic [CSR_DATA_W-1:0] shadow_screen_h = 11'(RESET_SCREEN_HEIGHT);
   logic [CSR_DATA_W-1:0] shadow_native_w = 11'(RESET_NATIVE_WIDTH);
   logic [CSR_DATA_W-1:0] shadow_native_h = 11'(RESET_NATIVE_HEIGHT);
   rot_type               shadow_rot = ROT_0;
   int unsigned           pos_x = 0;
   int unsigned           pos_y = 0;

   readout_type  expected_readouts[$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_idle_pct = 32;
   int unsigned  recv_idle_pct = 50;
   int unsigned  hold_requests = 0;
   int unsigned  hold_served = 0;
   int unsigned  hold_left = 0;
   stim_row_type directed_rows [NUM_DIRECTED];

   rotated_framebuffer_bmp_readout i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned clip_dimension(logic [CSR_DATA_W-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > MAX_DIMENSION_DEF) begin
         return MAX_DIMENSION_DEF;
      end
      return v;
   endfunction

   // inverse rotation, 32-bit wrapping, cut to the 20-bit index like the hardware
   function automatic logic [INDEX_W-1:0] native_pixel_index(int unsigned sx, int unsigned sy);
      int unsigned nw, nh, bx, by, idx;
      nw = clip_dimension(shadow_native_w);
      nh = clip_dimension(shadow_native_h);
      case (shadow_rot)
         ROT_90: begin
            bx = nw - 1 - sy;
            by = sx;
         end
         ROT_180: begin
            bx = nw - 1 - sx;
            by = nh - 1 - sy;
         end
         ROT_270: begin
            bx = sy;
            by = nh - 1 - sx;
         end
         default: begin
            bx = sx;
            by = sy;
         end
      endcase
      idx = by * nw + bx;
      return idx[INDEX_W-1:0];
   endfunction

   function automatic readout_type scan_step(logic cmd, logic [7:0] high, logic [7:0] low);
      readout_type res;
      int unsigned sw, sh, stride, ofs, r5, g6, b5;
      sw = clip_dimension(shadow_screen_w);
      sh = clip_dimension(shadow_screen_h);
      res = '0;
      if (cmd == CMD_BEGIN) begin
         pos_x = 0;
         pos_y = 0;
         res.fetch_index = native_pixel_index(0, 0);
         return res;
      end
      if (pos_x >= sw || pos_y >= sh) begin
         pos_x = 0;
         pos_y = 0;
      end
      stride = ((sw * 3 + 3) / 4) * 4;
      ofs = BMP_HEADER_BYTES + (sh - 1 - pos_y) * stride + pos_x * 3;
      r5 = high[7:3];
      g6 = {high[2:0], low[7:5]};
      b5 = low[4:0];
      res.pixel_valid = 1'b1;
      res.bmp_offset  = ofs[OFFSET_W-1:0];
      res.blue        = 8'((b5 * 255) / 31);
      res.green       = 8'((g6 * 255) / 63);
      res.red         = 8'((r5 * 255) / 31);
      res.frame_last  = (pos_x == sw - 1) && (pos_y == sh - 1);
      pos_x++;
      if (pos_x >= sw) begin
         pos_x = 0;
         pos_y++;
         if (pos_y >= sh) begin
            pos_y = 0;
         end
      end
      res.fetch_index = native_pixel_index(pos_x, pos_y);
      return res;
   endfunction

   function automatic stim_row_type item_row(logic cmd, logic [7:0] high, logic [7:0] low);
      stim_row_type row;
      row = '0;
      row.cmd = cmd;
      row.high = high;
      row.low = low;
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic cmd, logic [7:0] high, logic [7:0] low,
                                              readout_type result);
      stim_row_type row;
      row = item_row(cmd, high, low);
      row.typed = 1'b1;
      row.result = result;
      return row;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type index, logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.index = index;
      row.value = value;
      return row;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic offer_item(logic cmd, logic [7:0] high, logic [7:0] low, bit typed,
                             readout_type typed_result);
      readout_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {low, high};
      do begin
         @(posedge clock);
      end while (!req_tready);
      predicted = scan_step(cmd, high, low);
      expected_readouts.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   task automatic wait_readout_drained();
      req_tvalid <= 1'b0;
      while (expected_readouts.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_SCREEN_WIDTH:  shadow_screen_w = value;
         CSR_SCREEN_HEIGHT: shadow_screen_h = value;
         CSR_NATIVE_WIDTH:  shadow_native_w = value;
         CSR_NATIVE_HEIGHT: shadow_native_h = value;
         CSR_ROTATION:      shadow_rot = rot_type'(value[1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // receiver: random stalls plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      readout_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readouts.size() == 0) begin
            $display("%0t: transfer with nothing expected, actual tdata %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_readouts.pop_front();
            compare_field("pixel_valid", want.pixel_valid, rsp_tuser);
            compare_field("bmp_offset", want.bmp_offset, rsp_tdata[OFS_LSB +: OFFSET_W]);
            compare_field("blue", want.blue, rsp_tdata[BLUE_LSB +: COLOR_W]);
            compare_field("green", want.green, rsp_tdata[GREEN_LSB +: COLOR_W]);
            compare_field("red", want.red, rsp_tdata[RED_LSB +: COLOR_W]);
            compare_field("fetch_index", want.fetch_index, rsp_tdata[FETCH_LSB +: INDEX_W]);
            compare_field("frame_last", want.frame_last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d transfers still expected", $time, expected_readouts.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned           random_count;
      int unsigned           sel, frame, n;
      bit                    hold_done;
      logic [CSR_DATA_W-1:0] sw, sh, nw, nh;
      rot_type               rot;
      logic                  cmd;

      directed_rows = '{
         typed_row(CMD_BEGIN, 8'h00, 8'h00, '{1'b0, 22'd0, 8'd0, 8'd0, 8'd0, 20'd0, 1'b0}),
         typed_row(CMD_PIXEL, 8'hFF, 8'hFF,
                   '{1'b1, 22'd229494, 8'd255, 8'd255, 8'd255, 20'd1, 1'b0}),
         typed_row(CMD_PIXEL, 8'h00, 8'h00, '{1'b1, 22'd229497, 8'd0, 8'd0, 8'd0, 20'd2, 1'b0}),
         item_row(CMD_PIXEL, 8'hF8, 8'h00),
         item_row(CMD_PIXEL, 8'h07, 8'hE0),
         item_row(CMD_PIXEL, 8'h00, 8'h1F),
         item_row(CMD_PIXEL, 8'hAA, 8'h55),
         item_row(CMD_PIXEL, 8'h55, 8'hAA),
         // zero sizes count as one; scan is now off screen and restarts
         csr_row(CSR_SCREEN_WIDTH, 11'd0),
         csr_row(CSR_SCREEN_HEIGHT, 11'd0),
         typed_row(CMD_PIXEL, 8'hFF, 8'hFF, '{1'b1, 22'd54, 8'd255, 8'd255, 8'd255, 20'd0, 1'b1}),
         item_row(CMD_PIXEL, 8'h3C, 8'hC3),
         csr_row(CSR_NATIVE_HEIGHT, 11'd2047),
         csr_row(CSR_ROTATION, 11'(ROT_270)),
         item_row(CMD_PIXEL, 8'h81, 8'h18),
         // oversize values clip to the maximum dimension
         csr_row(CSR_SCREEN_WIDTH, 11'd2047),
         csr_row(CSR_SCREEN_HEIGHT, 11'd2047),
         csr_row(CSR_NATIVE_WIDTH, 11'd2047),
         csr_row(CSR_ROTATION, 11'(ROT_180)),
         typed_row(CMD_BEGIN, 8'h00, 8'h00,
                   '{1'b0, 22'd0, 8'd0, 8'd0, 8'd0, 20'hFFFFF, 1'b0}),
         typed_row(CMD_PIXEL, 8'hFF, 8'hFF,
                   '{1'b1, 22'd3142710, 8'd255, 8'd255, 8'd255, 20'd1048574, 1'b0}),
         csr_row(CSR_ROTATION, 11'(ROT_90)),
         item_row(CMD_PIXEL, 8'h12, 8'h34),
         item_row(CMD_BEGIN, 8'h00, 8'h00),
         csr_row(CSR_ROTATION, 11'(ROT_0))
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_readout_drained();
            write_register(directed_rows[i].index, directed_rows[i].value);
         end else begin
            offer_item(directed_rows[i].cmd, directed_rows[i].high, directed_rows[i].low,
                       directed_rows[i].typed, directed_rows[i].result);
         end
      end

      random_count = 0;
      hold_done = 1'b0;
      while (random_count < RANDOM_ITEMS) begin
         if (random_count < RANDOM_ITEMS / 3) begin
            send_idle_pct = 32;
            recv_idle_pct = 50;
         end else if (random_count < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // mostly small screens so frames wrap often
         sel = $urandom_range(9);
         if (sel < 7) begin
            sw = 11'($urandom_range(1, 12));
            sh = 11'($urandom_range(1, 8));
         end else if (sel == 7) begin
            sw = 11'($urandom_range(2047));
            sh = 11'($urandom_range(2047));
         end else if (sel == 8) begin
            sw = 11'($urandom_range(900, 1024));
            sh = 11'($urandom_range(1, 2));
         end else begin
            sw = $urandom_range(1) ? 11'd2047 : 11'd0;
            sh = $urandom_range(1) ? 11'd2047 : 11'd0;
         end
         rot = rot_type'($urandom_range(3));
         if ($urandom_range(9) < 7) begin
            nw = (rot == ROT_0 || rot == ROT_180) ? sw : sh;
            nh = (rot == ROT_0 || rot == ROT_180) ? sh : sw;
         end else begin
            nw = 11'($urandom_range(2047));
            nh = 11'($urandom_range(2047));
         end

         wait_readout_drained();
         write_register(CSR_SCREEN_WIDTH, sw);
         write_register(CSR_SCREEN_HEIGHT, sh);
         write_register(CSR_NATIVE_WIDTH, nw);
         write_register(CSR_NATIVE_HEIGHT, nh);
         write_register(CSR_ROTATION, 11'(rot));

         if (!hold_done && random_count >= 1200) begin
            @(posedge clock);
            hold_requests++;
            @(negedge clock);
            hold_done = 1'b1;
         end

         frame = clip_dimension(sw) * clip_dimension(sh);
         n = frame * $urandom_range(1, 3) + $urandom_range(3);
         if (n > 150) begin
            n = $urandom_range(60, 150);
         end
         if ($urandom_range(1)) begin
            offer_item(CMD_BEGIN, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
            random_count++;
         end
         repeat (n) begin
            cmd = ($urandom_range(99) < 4) ? CMD_BEGIN : CMD_PIXEL;
            offer_item(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
            random_count++;
         end
      end

      wait_readout_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/rfb_pkg.sv
rtl/rfb_pixel_calc.sv
rtl/rotated_framebuffer_bmp_readout.sv
rtl/rfb_checker.sv
sim/rotated_framebuffer_bmp_readout_tb.sv
